>>> rtl/facet_solid_angle_core_defines.svh
// Assertion macros for the facet solid angle core
`ifndef FACET_SOLID_ANGLE_CORE_DEFINES_SVH
`define FACET_SOLID_ANGLE_CORE_DEFINES_SVH

// checked only out of reset
`define FSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FSA_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/fsa_pkg.sv
package fsa_pkg;

    localparam int VERTEX_DEPTH_DEF = 4096;
    localparam int CORDIC_STEPS_DEF = 32;

    localparam int IDX_W      = 12;
    localparam int COORD_W    = 32;
    localparam int VTX_W      = 3 * COORD_W;
    localparam int ANGLE_W    = 32;
    localparam int SQRT_STEPS = 32;
    localparam int WIDE_W     = 100;
    localparam int MAG_W      = 98;
    localparam int NORM_W     = 61;
    localparam int CHUNK_W    = 16;
    localparam int CHUNKS     = 7;
    localparam int PAD_W      = CHUNKS * CHUNK_W;

    localparam int ANGLE_LIMIT = 1686629713;
    localparam logic signed [63:0] HALF_PI_Q60    = 64'sh1921FB54442D1846;
    localparam logic signed [63:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FACET = 1'b1;

    function automatic logic signed [63:0] smul32(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    // arctan(2^-i) in Q3.60, odd power series, restoring long division per term
    function automatic logic [63:0] atan_step(input int i);
        logic [63:0] sum;
        logic [63:0] q;
        logic [63:0] rem;
        int k;
        int d;
        int e;
        int b;
        sum = '0;
        if (i == 0) begin
            return QUARTER_PI_Q60;
        end
        for (k = 0; k < 31; k++) begin
            d = 2 * k + 1;
            if (i * d <= 60) begin
                e = 60 - i * d;
                q = '0;
                rem = '0;
                for (b = 60; b >= 0; b--) begin
                    rem = {rem[62:0], 1'(b == e)};
                    q = q << 1;
                    if (rem >= 64'(d)) begin
                        rem = rem - 64'(d);
                        q[0] = 1'b1;
                    end
                end
                if ((k % 2) == 1) begin
                    sum = sum - q;
                end
                else begin
                    sum = sum + q;
                end
            end
        end
        return sum;
    endfunction

endpackage

>>> rtl/fsa_ram.sv
module fsa_ram #(
    parameter int WIDTH = fsa_pkg::VTX_W,
    parameter int DEPTH = fsa_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/facet_solid_angle_core.sv
// Throughput: one request per cycle; the pipeline moves as a whole and holds while
// a result waits at the output.
// The vertex table is read through three copies, one per corner, all written together.
// Reset (rst_n low) clears the valid bits only; vertex entries are undefined until written.
module facet_solid_angle_core #(
    parameter int VERTEX_DEPTH = fsa_pkg::VERTEX_DEPTH_DEF,
    parameter int CORDIC_STEPS = fsa_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [11:0]        vertex_slot,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [11:0]        corner_first,
    input  logic [11:0]        corner_second,
    input  logic [11:0]        corner_third,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] solid_angle
);
    import fsa_pkg::*;

    localparam int AW = $clog2(VERTEX_DEPTH);

    logic adv;
    logic accept;
    logic out_valid_reg;
    logic signed [ANGLE_W-1:0] solid_angle_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // vertex tables
    logic             wr_en;
    logic [VTX_W-1:0] wr_data;
    logic [IDX_W-1:0] corner [3];
    logic [VTX_W-1:0] rd_data [3];

    assign corner[0] = corner_first;
    assign corner[1] = corner_second;
    assign corner[2] = corner_third;
    assign wr_data   = {coord_x, coord_y, coord_z};
    assign wr_en     = accept && (cmd == CMD_LOAD) && (32'(vertex_slot) < VERTEX_DEPTH);

    genvar g;
    for (g = 0; g < 3; g++)
    begin : g_tab
        fsa_ram #(
            .WIDTH(VTX_W),
            .DEPTH(VERTEX_DEPTH)
        ) u_ram (
            .clk    (clk),
            .wr_en  (wr_en),
            .wr_addr(AW'(vertex_slot)),
            .wr_data(wr_data),
            .rd_en  (adv),
            .rd_addr(AW'(corner[g])),
            .rd_data(rd_data[g])
        );
    end

    // stage valids
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic e1_valid_reg, e2_valid_reg, e3_valid_reg, e4_valid_reg;
    logic l1_valid_reg, l2_valid_reg, h1_valid_reg, h2_valid_reg, pr_valid_reg;
    logic sq_valid_reg [SQRT_STEPS];
    logic cd_valid_reg [CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            e4_valid_reg  <= 1'b0;
            l1_valid_reg  <= 1'b0;
            l2_valid_reg  <= 1'b0;
            h1_valid_reg  <= 1'b0;
            h2_valid_reg  <= 1'b0;
            pr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept && (cmd == CMD_FACET);
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            e1_valid_reg  <= sq_valid_reg[SQRT_STEPS-1];
            e2_valid_reg  <= e1_valid_reg;
            e3_valid_reg  <= e2_valid_reg;
            e4_valid_reg  <= e3_valid_reg;
            l1_valid_reg  <= e4_valid_reg;
            l2_valid_reg  <= l1_valid_reg;
            h1_valid_reg  <= l2_valid_reg;
            h2_valid_reg  <= h1_valid_reg;
            pr_valid_reg  <= h2_valid_reg;
            out_valid_reg <= cd_valid_reg[CORDIC_STEPS-1];
        end
    end

    // stage 1: table read, out-of-range corners read as zero
    logic [2:0] s1_rng_reg;
    logic signed [COORD_W-1:0] vtx [3][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s1_rng_reg[c] <= 32'(corner[c]) < VERTEX_DEPTH;
            end
        end
    end

    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                vtx[v][c] = s1_rng_reg[v] ? $signed(rd_data[v][VTX_W-1-COORD_W*c -: COORD_W])
                                          : '0;
            end
        end
    end

    // stage 2: all 32x32 products
    logic [63:0]               s2_sq_reg [3][3];
    logic signed [63:0]        s2_cx_reg [6];
    logic signed [63:0]        s2_dt_reg [3][3];
    logic signed [COORD_W-1:0] s2_p_reg  [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int v = 0; v < 3; v++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s2_sq_reg[v][c] <= smul32(vtx[v][c], vtx[v][c]);
                end
                s2_p_reg[v] <= vtx[0][v];
            end
            for (int c = 0; c < 3; c++)
            begin
                s2_dt_reg[0][c] <= smul32(vtx[1][c], vtx[2][c]);
                s2_dt_reg[1][c] <= smul32(vtx[2][c], vtx[0][c]);
                s2_dt_reg[2][c] <= smul32(vtx[0][c], vtx[1][c]);
            end
            s2_cx_reg[0] <= smul32(vtx[1][1], vtx[2][2]);
            s2_cx_reg[1] <= smul32(vtx[1][2], vtx[2][1]);
            s2_cx_reg[2] <= smul32(vtx[1][2], vtx[2][0]);
            s2_cx_reg[3] <= smul32(vtx[1][0], vtx[2][2]);
            s2_cx_reg[4] <= smul32(vtx[1][0], vtx[2][1]);
            s2_cx_reg[5] <= smul32(vtx[1][1], vtx[2][0]);
        end
    end

    // stage 3: squared norms, cross product, dot products
    logic [63:0]               s3_ss_reg  [3];
    logic signed [64:0]        s3_cr_reg  [3];
    logic signed [65:0]        s3_dot_reg [3];
    logic signed [COORD_W-1:0] s3_p_reg   [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int v = 0; v < 3; v++)
            begin
                s3_ss_reg[v]  <= s2_sq_reg[v][0] + s2_sq_reg[v][1] + s2_sq_reg[v][2];
                s3_cr_reg[v]  <= 65'(s2_cx_reg[2*v]) - 65'(s2_cx_reg[2*v+1]);
                s3_dot_reg[v] <= 66'(s2_dt_reg[v][0]) + 66'(s2_dt_reg[v][1])
                               + 66'(s2_dt_reg[v][2]);
                s3_p_reg[v]   <= s2_p_reg[v];
            end
        end
    end

    // stage 4: triple product halves
    logic signed [64:0] s4_pl_reg  [3];
    logic signed [64:0] s4_ph_reg  [3];
    logic [63:0]        s4_ss_reg  [3];
    logic signed [65:0] s4_dot_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s4_pl_reg[c]  <= 65'(s3_p_reg[c]) * 65'($signed({1'b0, s3_cr_reg[c][31:0]}));
                s4_ph_reg[c]  <= 65'(s3_p_reg[c]) * 65'($signed(s3_cr_reg[c][64:32]));
                s4_ss_reg[c]  <= s3_ss_reg[c];
                s4_dot_reg[c] <= s3_dot_reg[c];
            end
        end
    end

    // stage 5: triple product
    logic signed [WIDE_W-1:0] s5_n_reg;
    logic [63:0]              s5_ss_reg  [3];
    logic signed [65:0]       s5_dot_reg [3];
    logic signed [WIDE_W-1:0] s5_n_next;

    always_comb
    begin
        s5_n_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            s5_n_next = s5_n_next + (WIDE_W'(s4_ph_reg[c]) <<< 32) + WIDE_W'(s4_pl_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_n_reg <= s5_n_next;
            for (int c = 0; c < 3; c++)
            begin
                s5_ss_reg[c]  <= s4_ss_reg[c];
                s5_dot_reg[c] <= s4_dot_reg[c];
            end
        end
    end

    // norms: one restoring square root step per stage
    logic [63:0]              sq_rem_reg  [SQRT_STEPS][3];
    logic [63:0]              sq_root_reg [SQRT_STEPS][3];
    logic signed [WIDE_W-1:0] sq_n_reg    [SQRT_STEPS];
    logic signed [65:0]       sq_dot_reg  [SQRT_STEPS][3];

    for (g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic                     vin;
        logic [63:0]              rem_in    [3];
        logic [63:0]              root_in   [3];
        logic signed [WIDE_W-1:0] n_in;
        logic signed [65:0]       dot_in    [3];
        logic [63:0]              trial     [3];
        logic [63:0]              rem_next  [3];
        logic [63:0]              root_next [3];

        if (g == 0)
        begin : g_head
            always_comb
            begin
                vin  = s5_valid_reg;
                n_in = s5_n_reg;
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c]  = s5_ss_reg[c];
                    root_in[c] = '0;
                    dot_in[c]  = s5_dot_reg[c];
                end
            end
        end
        else
        begin : g_body
            always_comb
            begin
                vin  = sq_valid_reg[g-1];
                n_in = sq_n_reg[g-1];
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c]  = sq_rem_reg[g-1][c];
                    root_in[c] = sq_root_reg[g-1][c];
                    dot_in[c]  = sq_dot_reg[g-1][c];
                end
            end
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                trial[c] = root_in[c] + BIT;
                if (rem_in[c] >= trial[c])
                begin
                    rem_next[c]  = rem_in[c] - trial[c];
                    root_next[c] = (root_in[c] >> 1) + BIT;
                end
                else
                begin
                    rem_next[c]  = rem_in[c];
                    root_next[c] = root_in[c] >> 1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[g] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_n_reg[g] <= n_in;
                for (int c = 0; c < 3; c++)
                begin
                    sq_rem_reg[g][c]  <= rem_next[c];
                    sq_root_reg[g][c] <= root_next[c];
                    sq_dot_reg[g][c]  <= dot_in[c];
                end
            end
        end
    end

    // denominator
    logic [31:0] nrm [3];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            nrm[c] = sq_root_reg[SQRT_STEPS-1][c][31:0];
        end
    end

    logic [63:0]              e1_n12_reg;
    logic [63:0]              e1_tl_reg [3];
    logic signed [66:0]       e1_th_reg [3];
    logic [31:0]              e1_n3_reg;
    logic signed [WIDE_W-1:0] e1_n_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_n12_reg <= 64'(nrm[0]) * 64'(nrm[1]);
            for (int c = 0; c < 3; c++)
            begin
                e1_tl_reg[c] <= 64'(nrm[c]) * 64'(sq_dot_reg[SQRT_STEPS-1][c][31:0]);
                e1_th_reg[c] <= 67'($signed({1'b0, nrm[c]}))
                              * 67'($signed(sq_dot_reg[SQRT_STEPS-1][c][65:32]));
            end
            e1_n3_reg <= nrm[2];
            e1_n_reg  <= sq_n_reg[SQRT_STEPS-1];
        end
    end

    logic [63:0]              e2_pl_reg;
    logic [63:0]              e2_ph_reg;
    logic signed [WIDE_W-1:0] e2_t_reg;
    logic signed [WIDE_W-1:0] e2_n_reg;
    logic signed [WIDE_W-1:0] e2_t_next;

    always_comb
    begin
        e2_t_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            e2_t_next = e2_t_next + (WIDE_W'(e1_th_reg[c]) <<< 32)
                      + $signed(WIDE_W'(e1_tl_reg[c]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e2_pl_reg <= 64'(e1_n12_reg[31:0]) * 64'(e1_n3_reg);
            e2_ph_reg <= 64'(e1_n12_reg[63:32]) * 64'(e1_n3_reg);
            e2_t_reg  <= e2_t_next;
            e2_n_reg  <= e1_n_reg;
        end
    end

    logic signed [WIDE_W-1:0] e3_d_reg;
    logic signed [WIDE_W-1:0] e3_n_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e3_d_reg <= $signed((WIDE_W'(e2_ph_reg) << 32) + WIDE_W'(e2_pl_reg)) + e2_t_reg;
            e3_n_reg <= e2_n_reg;
        end
    end

    logic [MAG_W-1:0] e4_an_reg;
    logic [MAG_W-1:0] e4_ad_reg;
    logic             e4_nneg_reg;
    logic             e4_dneg_reg;
    logic             e4_nz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e4_an_reg   <= MAG_W'(e3_n_reg < 0 ? -e3_n_reg : e3_n_reg);
            e4_ad_reg   <= MAG_W'(e3_d_reg < 0 ? -e3_d_reg : e3_d_reg);
            e4_nneg_reg <= e3_n_reg < 0;
            e4_dneg_reg <= e3_d_reg < 0;
            e4_nz_reg   <= e3_n_reg != 0;
        end
    end

    // normalise: leading zeros per chunk, then overall, then two shift steps
    logic [PAD_W-1:0] l1_m;
    logic [CHUNKS-1:0] l1_cnz_next;
    logic [3:0]        l1_clz_next [CHUNKS];

    always_comb
    begin
        l1_m = PAD_W'(e4_an_reg | e4_ad_reg);
        for (int ch = 0; ch < CHUNKS; ch++)
        begin
            l1_cnz_next[ch] = |l1_m[ch*CHUNK_W +: CHUNK_W];
            l1_clz_next[ch] = '0;
            for (int b = 0; b < CHUNK_W; b++)
            begin
                if (l1_m[ch*CHUNK_W + b])
                begin
                    l1_clz_next[ch] = 4'(CHUNK_W - 1 - b);
                end
            end
        end
    end

    logic [MAG_W-1:0]  l1_an_reg;
    logic [MAG_W-1:0]  l1_ad_reg;
    logic              l1_nneg_reg;
    logic              l1_dneg_reg;
    logic              l1_nz_reg;
    logic [CHUNKS-1:0] l1_cnz_reg;
    logic [3:0]        l1_clz_reg [CHUNKS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_an_reg   <= e4_an_reg;
            l1_ad_reg   <= e4_ad_reg;
            l1_nneg_reg <= e4_nneg_reg;
            l1_dneg_reg <= e4_dneg_reg;
            l1_nz_reg   <= e4_nz_reg;
            l1_cnz_reg  <= l1_cnz_next;
            for (int ch = 0; ch < CHUNKS; ch++)
            begin
                l1_clz_reg[ch] <= l1_clz_next[ch];
            end
        end
    end

    logic [6:0] l2_lz;
    logic [6:0] l2_s_next;

    always_comb
    begin
        l2_lz = '0;
        for (int ch = 0; ch < CHUNKS; ch++)
        begin
            if (l1_cnz_reg[ch])
            begin
                l2_lz = 7'((CHUNKS - 1 - ch) * CHUNK_W) + 7'(l1_clz_reg[ch]);
            end
        end
        l2_s_next = l2_lz - 7'(PAD_W - MAG_W);
    end

    logic [MAG_W-1:0] l2_an_reg;
    logic [MAG_W-1:0] l2_ad_reg;
    logic             l2_nneg_reg;
    logic             l2_dneg_reg;
    logic             l2_nz_reg;
    logic [6:0]       l2_s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l2_an_reg   <= l1_an_reg;
            l2_ad_reg   <= l1_ad_reg;
            l2_nneg_reg <= l1_nneg_reg;
            l2_dneg_reg <= l1_dneg_reg;
            l2_nz_reg   <= l1_nz_reg;
            l2_s_reg    <= l2_s_next;
        end
    end

    logic [MAG_W-1:0] h1_an_reg;
    logic [MAG_W-1:0] h1_ad_reg;
    logic             h1_nneg_reg;
    logic             h1_dneg_reg;
    logic             h1_nz_reg;
    logic [3:0]       h1_s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_an_reg   <= l2_an_reg << {l2_s_reg[6:4], 4'b0000};
            h1_ad_reg   <= l2_ad_reg << {l2_s_reg[6:4], 4'b0000};
            h1_nneg_reg <= l2_nneg_reg;
            h1_dneg_reg <= l2_dneg_reg;
            h1_nz_reg   <= l2_nz_reg;
            h1_s_reg    <= l2_s_reg[3:0];
        end
    end

    logic [MAG_W-1:0]  h2_an_sh;
    logic [MAG_W-1:0]  h2_ad_sh;
    logic [NORM_W-1:0] h2_an_reg;
    logic [NORM_W-1:0] h2_ad_reg;
    logic              h2_nneg_reg;
    logic              h2_dneg_reg;
    logic              h2_nz_reg;

    assign h2_an_sh = h1_an_reg << h1_s_reg;
    assign h2_ad_sh = h1_ad_reg << h1_s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h2_an_reg   <= h2_an_sh[MAG_W-1 -: NORM_W];
            h2_ad_reg   <= h2_ad_sh[MAG_W-1 -: NORM_W];
            h2_nneg_reg <= h1_nneg_reg;
            h2_dneg_reg <= h1_dneg_reg;
            h2_nz_reg   <= h1_nz_reg;
        end
    end

    // sign restore, and quadrant fold for a negative denominator
    logic signed [63:0] pr_xa;
    logic signed [63:0] pr_ya;
    logic signed [63:0] pr_x_next;
    logic signed [63:0] pr_y_next;
    logic signed [63:0] pr_z_next;

    always_comb
    begin
        pr_xa = $signed(64'(h2_ad_reg));
        pr_ya = $signed(64'(h2_an_reg));
        if (!h2_dneg_reg)
        begin
            pr_x_next = pr_xa;
            pr_y_next = h2_nneg_reg ? -pr_ya : pr_ya;
            pr_z_next = '0;
        end
        else if (!h2_nneg_reg)
        begin
            pr_x_next = pr_ya;
            pr_y_next = pr_xa;
            pr_z_next = HALF_PI_Q60;
        end
        else
        begin
            pr_x_next = pr_ya;
            pr_y_next = -pr_xa;
            pr_z_next = -HALF_PI_Q60;
        end
    end

    logic signed [63:0] pr_x_reg;
    logic signed [63:0] pr_y_reg;
    logic signed [63:0] pr_z_reg;
    logic               pr_nz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_x_reg  <= pr_x_next;
            pr_y_reg  <= pr_y_next;
            pr_z_reg  <= pr_z_next;
            pr_nz_reg <= h2_nz_reg;
        end
    end

    // vectoring CORDIC, one step per stage
    logic signed [63:0] cd_x_reg  [CORDIC_STEPS];
    logic signed [63:0] cd_y_reg  [CORDIC_STEPS];
    logic signed [63:0] cd_z_reg  [CORDIC_STEPS];
    logic               cd_nz_reg [CORDIC_STEPS];

    for (g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        localparam logic signed [63:0] ANG = atan_step(g);
        logic               vin;
        logic               nz_in;
        logic signed [63:0] x_in;
        logic signed [63:0] y_in;
        logic signed [63:0] z_in;
        logic signed [63:0] x_next;
        logic signed [63:0] y_next;
        logic signed [63:0] z_next;

        if (g == 0)
        begin : g_head
            assign vin   = pr_valid_reg;
            assign nz_in = pr_nz_reg;
            assign x_in  = pr_x_reg;
            assign y_in  = pr_y_reg;
            assign z_in  = pr_z_reg;
        end
        else
        begin : g_body
            assign vin   = cd_valid_reg[g-1];
            assign nz_in = cd_nz_reg[g-1];
            assign x_in  = cd_x_reg[g-1];
            assign y_in  = cd_y_reg[g-1];
            assign z_in  = cd_z_reg[g-1];
        end

        always_comb
        begin
            if (y_in >= 0)
            begin
                x_next = x_in + (y_in >>> g);
                y_next = y_in - (x_in >>> g);
                z_next = z_in + ANG;
            end
            else
            begin
                x_next = x_in - (y_in >>> g);
                y_next = y_in + (x_in >>> g);
                z_next = z_in - ANG;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_valid_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                cd_valid_reg[g] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cd_x_reg[g]  <= x_next;
                cd_y_reg[g]  <= y_next;
                cd_z_reg[g]  <= z_next;
                cd_nz_reg[g] <= nz_in;
            end
        end
    end

    // 2*z in Q4.28, rounded and clamped
    logic signed [63:0]        rnd;
    logic signed [63:0]        clamped;
    logic signed [ANGLE_W-1:0] solid_angle_next;

    always_comb
    begin
        rnd = (cd_z_reg[CORDIC_STEPS-1] + 64'sd1073741824) >>> 31;
        if (rnd > 64'(ANGLE_LIMIT))
        begin
            clamped = 64'(ANGLE_LIMIT);
        end
        else if (rnd < -64'(ANGLE_LIMIT))
        begin
            clamped = -64'(ANGLE_LIMIT);
        end
        else
        begin
            clamped = rnd;
        end
        solid_angle_next = cd_nz_reg[CORDIC_STEPS-1] ? ANGLE_W'(clamped) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            solid_angle_reg <= solid_angle_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign solid_angle = solid_angle_reg;

endmodule

>>> rtl/fsa_checker.sv
`include "facet_solid_angle_core_defines.svh"

module fsa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] solid_angle
);
    import fsa_pkg::*;

    `FSA_ASSERT_NR(a_idle_in_reset, !rst_n |-> !out_valid, "result shown during reset")
    `FSA_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "request refused with output empty")
    `FSA_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(solid_angle), "stalled result changed")
    `FSA_ASSERT(a_angle_range, out_valid |-> (solid_angle <= ANGLE_LIMIT && solid_angle >= -ANGLE_LIMIT), "angle outside two pi")

endmodule

bind facet_solid_angle_core fsa_checker u_fsa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .solid_angle(solid_angle)
);

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsa_pkg::*;

    localparam int DEPTH = 4096;
    localparam int STEPS = 32;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [11:0]        vertex_slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [11:0]        corner_first;
    logic [11:0]        corner_second;
    logic [11:0]        corner_third;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] solid_angle;

    facet_solid_angle_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .vertex_slot  (vertex_slot),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .corner_first (corner_first),
        .corner_second(corner_second),
        .corner_third (corner_third),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .solid_angle  (solid_angle)
    );

    typedef struct {
        logic               op;
        logic [11:0]        slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [11:0]        ca;
        logic [11:0]        cb;
        logic [11:0]        cc;
        bit                 fixed;
        logic signed [31:0] angle;
    } request_t;

    logic signed [31:0] mesh_x [DEPTH];
    logic signed [31:0] mesh_y [DEPTH];
    logic signed [31:0] mesh_z [DEPTH];
    bit                 loaded [DEPTH];
    int                 loaded_slots[$];
    logic signed [63:0] arc_table [STEPS];
    logic signed [31:0] pending_angles[$];
    int                 errors;
    bit                 cur_fixed;
    logic signed [31:0] cur_angle;
    bit                 hold_off;
    bit                 quiet;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic signed [63:0] arc_of(int i);
        logic signed [63:0] sum;
        logic [63:0] t;
        int k;
        sum = '0;
        if (i == 0)
            return QUARTER_PI_Q60;
        for (k = 0; i * (2 * k + 1) <= 60; k++)
        begin
            t = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
            if (k % 2 == 1)
                sum = sum - t;
            else
                sum = sum + t;
        end
        return sum;
    endfunction

    function automatic logic [63:0] root_of(logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        int i;
        rem = v;
        root = '0;
        bitv = 64'd1 << 62;
        for (i = 0; i < 32; i++)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] length_of(logic signed [31:0] a, logic signed [31:0] b,
                                              logic signed [31:0] c);
        logic signed [63:0] a6, b6, c6;
        a6 = a;
        b6 = b;
        c6 = c;
        return root_of(64'(a6 * a6) + 64'(b6 * b6) + 64'(c6 * c6));
    endfunction

    function automatic logic signed [31:0] facet_angle(int ia, int ib, int ic);
        logic signed [127:0] p[3], q[3], r[3];
        logic signed [127:0] num, den, an, ad, n1, n2, n3;
        logic [127:0] m;
        logic signed [63:0] x, y, z, dx, dy, res;
        int len, i;
        bit nneg, dneg;
        p[0] = mesh_x[ia]; p[1] = mesh_y[ia]; p[2] = mesh_z[ia];
        q[0] = mesh_x[ib]; q[1] = mesh_y[ib]; q[2] = mesh_z[ib];
        r[0] = mesh_x[ic]; r[1] = mesh_y[ic]; r[2] = mesh_z[ic];
        num = p[0] * (q[1] * r[2] - q[2] * r[1]) + p[1] * (q[2] * r[0] - q[0] * r[2])
            + p[2] * (q[0] * r[1] - q[1] * r[0]);
        if (num == 0)
            return 0;
        n1 = {64'd0, length_of(p[0][31:0], p[1][31:0], p[2][31:0])};
        n2 = {64'd0, length_of(q[0][31:0], q[1][31:0], q[2][31:0])};
        n3 = {64'd0, length_of(r[0][31:0], r[1][31:0], r[2][31:0])};
        den = n1 * n2 * n3
            + n1 * (q[0] * r[0] + q[1] * r[1] + q[2] * r[2])
            + n2 * (r[0] * p[0] + r[1] * p[1] + r[2] * p[2])
            + n3 * (p[0] * q[0] + p[1] * q[1] + p[2] * q[2]);
        nneg = num < 0;
        dneg = den < 0;
        an = nneg ? -num : num;
        ad = dneg ? -den : den;
        m = an | ad;
        len = 0;
        for (i = 127; i >= 0; i--)
            if (len == 0 && m[i])
                len = i + 1;
        if (len > 61)
        begin
            an = an >> (len - 61);
            ad = ad >> (len - 61);
        end
        else
        begin
            an = an << (61 - len);
            ad = ad << (61 - len);
        end
        x = dneg ? -ad[63:0] : ad[63:0];
        y = nneg ? -an[63:0] : an[63:0];
        z = 0;
        if (dneg)
        begin
            dx = x;
            if (!nneg)
            begin
                x = y;
                y = -dx;
                z = HALF_PI_Q60;
            end
            else
            begin
                x = -y;
                y = dx;
                z = -HALF_PI_Q60;
            end
        end
        for (i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + arc_table[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - arc_table[i];
            end
        end
        res = (z + (64'sd1 <<< 30)) >>> 31;
        if (res > ANGLE_LIMIT)
            res = ANGLE_LIMIT;
        if (res < -ANGLE_LIMIT)
            res = -ANGLE_LIMIT;
        return res[31:0];
    endfunction

    // predictor updates at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            if (cmd == CMD_LOAD)
            begin
                mesh_x[vertex_slot] = coord_x;
                mesh_y[vertex_slot] = coord_y;
                mesh_z[vertex_slot] = coord_z;
                if (!loaded[vertex_slot])
                    loaded_slots.push_back(vertex_slot);
                loaded[vertex_slot] = 1'b1;
            end
            else if (cur_fixed)
                pending_angles.push_back(cur_angle);
            else
                pending_angles.push_back(facet_angle(corner_first, corner_second,
                                                     corner_third));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_angles.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d", $time,
                         solid_angle);
                errors++;
            end
            else
            begin
                if (solid_angle !== pending_angles[0])
                begin
                    $display("%0t: solid_angle mismatch, expected %0d, actual %0d", $time,
                             pending_angles[0], solid_angle);
                    errors++;
                end
                void'(pending_angles.pop_front());
            end
        end
    end

    initial
    begin
        int w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            w = quiet ? 0 : $urandom_range(0, 19);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send(request_t rq);
        int gap;
        cmd <= rq.op;
        vertex_slot <= rq.slot;
        coord_x <= rq.x;
        coord_y <= rq.y;
        coord_z <= rq.z;
        corner_first <= rq.ca;
        corner_second <= rq.cb;
        corner_third <= rq.cc;
        cur_fixed <= rq.fixed;
        cur_angle <= rq.angle;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic request_t load_row(int s, int x, int y, int z);
        request_t rq;
        rq = '{CMD_LOAD, 12'(s), x, y, z, 0, 0, 0, 1'b0, 0};
        return rq;
    endfunction

    function automatic request_t facet_row(int a, int b, int c, bit fx, int ang);
        request_t rq;
        rq = '{CMD_FACET, 0, 0, 0, 0, 12'(a), 12'(b), 12'(c), fx, ang};
        return rq;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: return v;
            1: return v >>> $urandom_range(8, 30);
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 0;
        endcase
    endfunction

    initial
    begin
        request_t rows[$];
        request_t rq;
        int n;
        for (n = 0; n < STEPS; n++)
            arc_table[n] = arc_of(n);
        errors = 0;
        hold_off = 1'b0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_LOAD;
        vertex_slot = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        corner_first = '0;
        corner_second = '0;
        corner_third = '0;
        cur_fixed = 1'b0;
        cur_angle = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(load_row(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        rows.push_back(load_row(4095, 32'h80000000, 32'h80000000, 32'h80000000));
        rows.push_back(load_row(1, 65536, 0, 0));
        rows.push_back(load_row(2, 0, 65536, 0));
        rows.push_back(load_row(3, 0, 0, 65536));
        rows.push_back(load_row(5, 0, 0, 0));
        rows.push_back(load_row(6, -65536, 1000, 0));
        rows.push_back(load_row(7, -65536, -1000, 100));
        rows.push_back(load_row(8, 32'h80000000, 32'h7fffffff, 1));
        rows.push_back(facet_row(1, 2, 3, 1'b0, 0));
        rows.push_back(facet_row(1, 3, 2, 1'b0, 0));
        rows.push_back(facet_row(1, 1, 2, 1'b1, 0));
        rows.push_back(facet_row(5, 5, 5, 1'b1, 0));
        rows.push_back(facet_row(0, 4095, 1, 1'b1, 0));
        rows.push_back(facet_row(1, 6, 7, 1'b0, 0));
        rows.push_back(facet_row(1, 7, 6, 1'b0, 0));
        rows.push_back(facet_row(0, 8, 4095, 1'b0, 0));
        rows.push_back(facet_row(8, 2, 3, 1'b0, 0));
        rows.push_back(facet_row(4095, 1, 2, 1'b0, 0));
        foreach (rows[i])
            send(rows[i]);

        for (n = 0; n < 950; n++)
        begin
            if (n % 120 == 60)
                quiet = !quiet;
            if (n == 300)
                hold_off = 1'b1;
            if (n == 600)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_angles.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) < 4)
                rq = load_row($urandom_range(0, 4095), rand_coord(), rand_coord(),
                              rand_coord());
            else
            begin
                rq = facet_row(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)],
                               loaded_slots[$urandom_range(0, loaded_slots.size() - 1)],
                               loaded_slots[$urandom_range(0, loaded_slots.size() - 1)],
                               1'b0, 0);
                if ($urandom_range(0, 15) == 0)
                    rq.cb = rq.ca;
            end
            send(rq);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
